// ===== hdl/bsip_pkg.sv =====
// Shared types and constants for the beacon security element parser.
// No dependencies; imported by every module of the block.
package bsip_pkg;

	// element walk phase
	typedef enum logic [1:0] {
		PH_ID   = 2'd0,
		PH_LEN  = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	// field being parsed inside an RSN element
	typedef enum logic [2:0] {
		ST_VERSION    = 3'd0,
		ST_PAIR_CNT   = 3'd1,
		ST_PAIR_SKIP  = 3'd2,
		ST_AKM_CNT_HI = 3'd3,
		ST_AKM        = 3'd4,
		ST_CAP_HI     = 3'd5,
		ST_DONE       = 3'd6
	} rsn_step_t;

	localparam logic [1:0] MODE_OPEN = 2'd0;
	localparam logic [1:0] MODE_WPA  = 2'd1;
	localparam logic [1:0] MODE_WPA2 = 2'd2;
	localparam logic [1:0] MODE_WPA3 = 2'd3;

	localparam logic [7:0] ID_RSN         = 8'd48;
	localparam logic [7:0] ID_VENDOR      = 8'd221;
	localparam logic [7:0] CAP_PMF_MASK   = 8'h80;
	localparam logic [7:0] AKM_SAE        = 8'h08;
	localparam logic [7:0] AKM_FT_SAE     = 8'h09;
	localparam logic [7:0] VENDOR_MIN_LEN = 8'd6;
	localparam logic [7:0] VENDOR_HDR_LEN = 8'd4;

	// RSN body offsets: group cipher ends at 5, pairwise count at 6..7
	localparam logic [7:0]  RSN_GROUP_END = 8'd5;
	localparam logic [7:0]  RSN_PAIR_LO   = 8'd6;
	localparam logic [7:0]  RSN_PAIR_HI   = 8'd7;
	localparam logic [18:0] RSN_PAIR_BASE = 19'd8;
	localparam logic [17:0] SKIP_MAX      = 18'h3FFFF;
	localparam logic [17:0] AKM_SUITE_LEN = 18'd4;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] security_mode;
		logic       pmf_capable;
	} result_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] id;
		logic [7:0] len;
		logic [7:0] off;
		rsn_step_t  step;
		logic [17:0] skip;
		logic [15:0] count;
		logic [7:0] hold;
		logic [1:0] t_mode;
		logic       t_pmf;
		logic       v_match;
		logic [1:0] c_mode;
		logic       c_pmf;
		logic       rsn_seen;
		logic       wpa_seen;
	} walk_state_t;

	localparam walk_state_t WALK_CLEAR = '{
		phase:    PH_ID,
		id:       8'd0,
		len:      8'd0,
		off:      8'd0,
		step:     ST_VERSION,
		skip:     18'd0,
		count:    16'd0,
		hold:     8'd0,
		t_mode:   MODE_WPA2,
		t_pmf:    1'b0,
		v_match:  1'b1,
		c_mode:   MODE_OPEN,
		c_pmf:    1'b0,
		rsn_seen: 1'b0,
		wpa_seen: 1'b0
	};

	// WPA vendor element header 00:50:F2, type 1
	function automatic logic [7:0] vendor_hdr_byte(input logic [1:0] idx);
		logic [7:0] v;
		unique case (idx)
			2'd0: v = 8'h00;
			2'd1: v = 8'h50;
			2'd2: v = 8'hF2;
			default: v = 8'h01;
		endcase
		return v;
	endfunction

endpackage

// ===== hdl/bsip_in_stage.sv =====
// Input register stage of the beacon security element parser.
// Depends on bsip_pkg (in_item_t).
module bsip_in_stage
	import bsip_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  logic [7:0] frame_byte,
	input  logic     last_byte,
	input  logic     advance,
	output logic     item_valid_s1,
	output in_item_t item_s1
);

	logic take;

	assign in_stall = item_valid_s1 & ~advance;
	assign take     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (take) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.frame_byte <= frame_byte;
			item_s1.last_byte  <= last_byte;
		end
	end

endmodule

// ===== hdl/bsip_walker.sv =====
// Element walker: frame state registers and the per-byte update.
// Depends on bsip_pkg (walk_state_t, in_item_t, result_t, constants).
module bsip_walker
	import bsip_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  in_item_t   item_s1,
	input  logic [7:0] start_offset,
	output logic       res_valid,
	output result_t    res
);

	localparam int POS_W = $clog2(MAX_FRAME_BYTES);
	localparam int CMP_W = (POS_W > 8) ? POS_W : 8;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_FRAME_BYTES - 1);

	walk_state_t cur_q, nxt;
	logic [POS_W-1:0] pos_q, pos_nxt;
	logic [7:0]  b;
	logic        walk_en;
	logic        elem_done;
	logic [18:0] pair_sum;
	logic [17:0] pair_skip;
	logic [17:0] off_ext;
	logic [8:0]  off_inc;

	assign b        = item_s1.frame_byte;
	assign walk_en  = CMP_W'(pos_q) >= CMP_W'(start_offset);
	assign off_ext  = {10'd0, cur_q.off};
	assign off_inc  = {1'b0, cur_q.off} + 9'd1;
	// pairwise suites end at 8 + 4 * count, clamped
	assign pair_sum  = RSN_PAIR_BASE + {1'b0, b, cur_q.hold, 2'b00};
	assign pair_skip = (pair_sum > {1'b0, SKIP_MAX}) ? SKIP_MAX : pair_sum[17:0];

	always_comb begin
		nxt       = cur_q;
		pos_nxt   = pos_q;
		elem_done = 1'b0;
		res_valid = 1'b0;
		res       = '{security_mode: MODE_OPEN, pmf_capable: 1'b0};
		if (advance) begin
			if (walk_en) begin
				unique case (cur_q.phase)
					PH_LEN: begin
						nxt.len   = b;
						nxt.off   = 8'd0;
						nxt.phase = PH_BODY;
						if (cur_q.id == ID_RSN) begin
							nxt.t_mode = MODE_WPA2;
							nxt.t_pmf  = 1'b0;
							nxt.step   = ST_VERSION;
							nxt.skip   = 18'd0;
							nxt.count  = 16'd0;
							nxt.hold   = 8'd0;
						end else if (cur_q.id == ID_VENDOR) begin
							nxt.v_match = 1'b1;
						end
						elem_done = (b == 8'd0);
					end
					PH_BODY: begin
						if (cur_q.id == ID_RSN) begin
							unique case (cur_q.step)
								ST_VERSION: begin
									if (cur_q.off == RSN_GROUP_END)
										nxt.step = ST_PAIR_CNT;
								end
								ST_PAIR_CNT: begin
									if (cur_q.off == RSN_PAIR_LO) begin
										nxt.hold = b;
									end else if (cur_q.off == RSN_PAIR_HI) begin
										nxt.count = {b, cur_q.hold};
										nxt.skip  = pair_skip;
										nxt.step  = ST_PAIR_SKIP;
									end
								end
								ST_PAIR_SKIP: begin
									if (off_ext == cur_q.skip) begin
										nxt.hold = b;
										nxt.step = ST_AKM_CNT_HI;
									end
								end
								ST_AKM_CNT_HI: begin
									nxt.count = {b, cur_q.hold};
									nxt.skip  = {9'd0, off_inc};
									nxt.step  = ST_AKM;
								end
								ST_AKM: begin
									// a suite that does not fit is read as capability
									if (cur_q.count == 16'd0 ||
									    cur_q.skip + AKM_SUITE_LEN > {10'd0, cur_q.len}) begin
										nxt.hold = b;
										nxt.step = ST_CAP_HI;
									end else if (off_ext == cur_q.skip + 18'd3) begin
										if (b == AKM_SAE || b == AKM_FT_SAE)
											nxt.t_mode = MODE_WPA3;
										nxt.count = cur_q.count - 16'd1;
										nxt.skip  = {9'd0, off_inc};
									end
								end
								ST_CAP_HI: begin
									if ((cur_q.hold & CAP_PMF_MASK) != 8'd0)
										nxt.t_pmf = 1'b1;
									nxt.step = ST_DONE;
								end
								default: begin
								end
							endcase
						end else if (cur_q.id == ID_VENDOR && cur_q.off < VENDOR_HDR_LEN) begin
							if (b != vendor_hdr_byte(cur_q.off[1:0]))
								nxt.v_match = 1'b0;
						end
						if (off_inc >= {1'b0, cur_q.len})
							elem_done = 1'b1;
						else
							nxt.off = off_inc[7:0];
					end
					default: begin
						nxt.id    = b;
						nxt.phase = PH_LEN;
					end
				endcase

				if (elem_done) begin
					if (cur_q.id == ID_RSN) begin
						nxt.c_mode   = nxt.t_mode;
						nxt.c_pmf    = nxt.t_pmf;
						nxt.rsn_seen = 1'b1;
					end else if (cur_q.id == ID_VENDOR) begin
						if (nxt.len >= VENDOR_MIN_LEN && nxt.v_match)
							nxt.wpa_seen = 1'b1;
					end
					nxt.phase = PH_ID;
				end
			end

			if (pos_q < POS_LAST)
				pos_nxt = pos_q + POS_W'(1);

			if (item_s1.last_byte) begin
				res_valid = 1'b1;
				if (nxt.rsn_seen) begin
					res.security_mode = nxt.c_mode;
					res.pmf_capable   = nxt.c_pmf;
				end else begin
					res.security_mode = nxt.wpa_seen ? MODE_WPA : MODE_OPEN;
					res.pmf_capable   = 1'b0;
				end
				nxt     = WALK_CLEAR;
				pos_nxt = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= WALK_CLEAR;
			pos_q <= '0;
		end else begin
			cur_q <= nxt;
			pos_q <= pos_nxt;
		end
	end

endmodule

// ===== hdl/beacon_security_ie_parser_top.sv =====
// Top level of the beacon security element parser: offset register, input
// stage, element walker and result register. Depends on bsip_pkg,
// bsip_in_stage and bsip_walker.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------
//   in      | in        | in_valid/in_stall  | frame_byte, last_byte
//   out     | out       | out_valid/out_stall| security_mode, pmf_capable
//   cfg     | in        | cfg_we             | cfg_wdata (element offset)
//
// One frame byte per cycle unless a held result stalls the input; a result is
// registered after its last byte is taken (input register, then result register).
// The byte walk is one combinational pass between the two registers.
// A held result stalls the input only when the next queued byte is a last byte.
// arst_n clears all frame state and sets the element offset to 36.
module beacon_security_ie_parser_top
	import bsip_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] frame_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] security_mode,
	output logic       pmf_capable,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	localparam logic [7:0] OFFSET_RESET = 8'd36;

	logic [7:0] start_offset_q;
	logic       item_valid_s1;
	in_item_t   item_s1;
	logic       advance;
	logic       res_valid;
	result_t    res;
	logic       out_valid_q;
	result_t    out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_offset_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			start_offset_q <= cfg_wdata;
		end
	end

	// non-final bytes never need the result register
	assign advance = item_valid_s1 &
	                 (~item_s1.last_byte | ~out_valid_q | ~out_stall);

	bsip_in_stage u_in_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.frame_byte    (frame_byte),
		.last_byte     (last_byte),
		.advance       (advance),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	bsip_walker #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_walker (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.item_s1      (item_s1),
		.start_offset (start_offset_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign security_mode = out_q.security_mode;
	assign pmf_capable   = out_q.pmf_capable;

endmodule

// ===== hdl/bsip_checker.sv =====
// Port-level checks for the beacon security element parser, bound to the
// top level. Depends on beacon_security_ie_parser_top and bsip_pkg.
module bsip_checker
	import bsip_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] security_mode,
	input logic       pmf_capable
);

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(security_mode) &&
		$stable(pmf_capable))
		else $error("result changed while stalled");

	// input backs up only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with result side free");

	// PMF only comes from an RSN element
	a_pmf_rsn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pmf_capable |-> security_mode == MODE_WPA2 ||
		security_mode == MODE_WPA3)
		else $error("PMF reported without RSN mode");

endmodule

bind beacon_security_ie_parser_top bsip_checker u_bsip_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.security_mode (security_mode),
	.pmf_capable   (pmf_capable)
);

// ===== test/bsip_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the beacon security element parser: mirrors the element walk
// on every accepted frame byte and checks each security result. Uses bsip_pkg.
module bsip_scoreboard
	import bsip_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] frame_byte,
	input  logic       last_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [1:0] security_mode,
	input  logic       pmf_capable,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	output int         mismatches,
	output int         pending,
	output int         checked
);

	localparam logic [7:0]  EID_RSN      = 8'd48;
	localparam logic [7:0]  EID_VENDOR   = 8'd221;
	localparam logic [7:0]  SUITE_SAE    = 8'h08;
	localparam logic [7:0]  SUITE_FT_SAE = 8'h09;
	localparam logic [31:0] WPA_OUI_TYPE = 32'h0050F201;
	localparam int          SKIP_CAP     = 'h3FFFF;

	logic [7:0]  ie_offset;
	int          pos;
	phase_t      phase;
	logic [7:0]  el_id;
	logic [7:0]  el_len;
	logic [7:0]  el_off;
	rsn_step_t   step;
	int          skip;
	logic [15:0] suites_left;
	logic [7:0]  hold;
	logic [1:0]  t_mode;
	logic        t_pmf;
	logic        hdr_ok;
	logic [1:0]  c_mode;
	logic        c_pmf;
	logic        rsn_done;
	logic        wpa_done;
	result_t     due_security[$];

	task automatic clear_frame_state();
		pos = 0;
		phase = PH_ID;
		el_id = 8'd0;
		el_len = 8'd0;
		el_off = 8'd0;
		step = ST_VERSION;
		skip = 0;
		suites_left = 16'd0;
		hold = 8'd0;
		t_mode = MODE_WPA2;
		t_pmf = 1'b0;
		hdr_ok = 1'b1;
		c_mode = MODE_OPEN;
		c_pmf = 1'b0;
		rsn_done = 1'b0;
		wpa_done = 1'b0;
	endtask

	// one body byte of an RSN element at element offset eo
	task automatic rsn_field_byte(input int eo, input logic [7:0] b);
		int n;
		case (step)
			ST_VERSION: if (eo == 5) step = ST_PAIR_CNT;
			ST_PAIR_CNT: begin
				if (eo == 6) begin
					hold = b;
				end else if (eo == 7) begin
					n = int'({b, hold});
					suites_left = n[15:0];
					skip = (8 + 4 * n > SKIP_CAP) ? SKIP_CAP : 8 + 4 * n;
					step = ST_PAIR_SKIP;
				end
			end
			ST_PAIR_SKIP: if (eo == skip) begin
				hold = b;
				step = ST_AKM_CNT_HI;
			end
			ST_AKM_CNT_HI: begin
				suites_left = {b, hold};
				skip = eo + 1;
				step = ST_AKM;
			end
			ST_AKM: begin
				// a suite that does not fit is read as the capability field
				if (suites_left == 16'd0 || skip + 4 > int'(el_len)) begin
					hold = b;
					step = ST_CAP_HI;
				end else if (eo == skip + 3) begin
					if (b == SUITE_SAE || b == SUITE_FT_SAE) t_mode = MODE_WPA3;
					suites_left = suites_left - 16'd1;
					skip = eo + 1;
				end
			end
			ST_CAP_HI: begin
				if (hold[7]) t_pmf = 1'b1;
				step = ST_DONE;
			end
			default: ;
		endcase
	endtask

	task automatic finish_element();
		if (el_id == EID_RSN) begin
			c_mode = t_mode;
			c_pmf = t_pmf;
			rsn_done = 1'b1;
		end else if (el_id == EID_VENDOR && el_len >= 8'd6 && hdr_ok) begin
			wpa_done = 1'b1;
		end
		phase = PH_ID;
	endtask

	task automatic walk_ie_byte(input logic [7:0] b);
		int eo;
		if (phase == PH_LEN) begin
			el_len = b;
			el_off = 8'd0;
			phase = PH_BODY;
			if (el_id == EID_RSN) begin
				t_mode = MODE_WPA2;
				t_pmf = 1'b0;
				step = ST_VERSION;
				skip = 0;
				suites_left = 16'd0;
				hold = 8'd0;
			end else if (el_id == EID_VENDOR) begin
				hdr_ok = 1'b1;
			end
			if (b == 8'd0) finish_element();
		end else if (phase == PH_BODY) begin
			eo = int'(el_off);
			if (el_id == EID_RSN) begin
				rsn_field_byte(eo, b);
			end else if (el_id == EID_VENDOR && eo < 4) begin
				if (b != WPA_OUI_TYPE[31 - 8 * eo -: 8]) hdr_ok = 1'b0;
			end
			if (eo + 1 >= int'(el_len)) finish_element();
			else el_off = 8'(eo + 1);
		end else begin
			el_id = b;
			phase = PH_LEN;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t r;
		if (!arst_n) begin
			ie_offset = 8'd36;
			clear_frame_state();
			due_security.delete();
			pending = 0;
			mismatches = 0;
			checked = 0;
		end else begin
			if (cfg_we) ie_offset = cfg_wdata;
			if (in_valid && !in_stall) begin
				if (pos >= int'(ie_offset)) walk_ie_byte(frame_byte);
				if (pos < MAX_FRAME_BYTES - 1) pos++;
				if (last_byte) begin
					if (rsn_done) begin
						r.security_mode = c_mode;
						r.pmf_capable = c_pmf;
					end else begin
						r.security_mode = wpa_done ? MODE_WPA : MODE_OPEN;
						r.pmf_capable = 1'b0;
					end
					due_security.push_back(r);
					clear_frame_state();
				end
			end
			if (out_valid && !out_stall) begin
				if (due_security.size() == 0) begin
					$display("%0t: result with none due: expected nothing, got mode %0d pmf %0d",
						$time, security_mode, pmf_capable);
					mismatches++;
				end else begin
					r = due_security.pop_front();
					checked++;
					if (security_mode !== r.security_mode) begin
						$display("%0t: security_mode mismatch: expected %0d, got %0d",
							$time, r.security_mode, security_mode);
						mismatches++;
					end
					if (pmf_capable !== r.pmf_capable) begin
						$display("%0t: pmf_capable mismatch: expected %0d, got %0d",
							$time, r.pmf_capable, pmf_capable);
						mismatches++;
					end
				end
			end
			pending = due_security.size();
		end
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the beacon security element parser: builds frames out of
// information elements and drives them with random gaps and stalls.
// Depends on bsip_pkg, bsip_scoreboard and beacon_security_ie_parser_top.
module tb;

	localparam int          CYCLE_LIMIT  = 2000000;
	localparam int          WANT_ITEMS   = 1850;
	localparam logic [7:0]  EID_RSN      = 8'd48;
	localparam logic [7:0]  EID_VENDOR   = 8'd221;
	localparam logic [7:0]  SUITE_PSK    = 8'h02;
	localparam logic [7:0]  SUITE_SAE    = 8'h08;
	localparam logic [7:0]  SUITE_FT_SAE = 8'h09;
	localparam logic [47:0] RSN_LEAD     = 48'h0100000FAC04;
	localparam logic [31:0] CIPHER_SUITE = 32'h000FAC04;
	localparam logic [31:0] WPA_HDR      = 32'h0050F201;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] frame_byte;
	logic       last_byte;
	logic       out_valid;
	logic       out_stall;
	logic [1:0] security_mode;
	logic       pmf_capable;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	int         mismatches;
	int         pending;
	int         checked;
	int         cycles = 0;
	logic [7:0] frm[$];
	logic [7:0] cur_offset;
	int         walked;
	int         sent_bytes;
	int         sent_frames;
	int         settings_used;
	bit         calm;

	beacon_security_ie_parser_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.frame_byte(frame_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.security_mode(security_mode),
		.pmf_capable(pmf_capable),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	bsip_scoreboard security_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.frame_byte(frame_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.security_mode(security_mode),
		.pmf_capable(pmf_capable),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.mismatches(mismatches),
		.pending(pending),
		.checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycles, pending);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver stalls: mostly short, a few long, with occasional free-running stretches
	initial begin
		int n;
		int r;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			r = $urandom_range(0, 99);
			n = (r < 10) ? $urandom_range(40, 200) : $urandom_range(1, 6);
			out_stall = 1'b0;
			repeat (n) @(negedge clk);
			r = $urandom_range(0, 99);
			n = (r < 60) ? $urandom_range(1, 2) : (r < 92) ? $urandom_range(3, 6) :
				$urandom_range(8, 25);
			out_stall = 1'b1;
			repeat (n) @(negedge clk);
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic logic [7:0] pick_akm();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return SUITE_SAE;
		if (r < 50) return SUITE_FT_SAE;
		if (r < 70) return SUITE_PSK;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic add_fill(input int n);
		repeat (n) frm.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic add_misc(input logic [7:0] id, input int n);
		frm.push_back(id);
		frm.push_back(n[7:0]);
		add_fill(n);
	endtask

	// vendor element; bad_at picks a header byte to corrupt (out of 0..3 for none)
	task automatic add_wpa(input int n, input int bad_at);
		int i;
		logic [7:0] flip;
		frm.push_back(EID_VENDOR);
		frm.push_back(n[7:0]);
		for (i = 0; i < n; i++) begin
			flip = 8'($urandom_range(1, 255));
			if (i >= 4) frm.push_back(8'($urandom_range(0, 255)));
			else if (i == bad_at) frm.push_back(WPA_HDR[31 - 8 * i -: 8] ^ flip);
			else frm.push_back(WPA_HDR[31 - 8 * i -: 8]);
		end
	endtask

	// RSN element; count fields may disagree with the suites actually present
	task automatic add_rsn(input int pair_field, input int pairs, input int akm_field,
			input int akms, input logic [7:0] akm_kind, input bit pmf, input int cap_len,
			input int extra);
		logic [7:0]  body[$];
		logic [31:0] suite;
		logic [7:0]  cap_lo;
		int i;
		int j;
		int len;
		for (i = 0; i < 6; i++) body.push_back(RSN_LEAD[47 - 8 * i -: 8]);
		body.push_back(pair_field[7:0]);
		body.push_back(pair_field[15:8]);
		for (i = 0; i < pairs * 4; i++) body.push_back(CIPHER_SUITE[31 - 8 * (i % 4) -: 8]);
		body.push_back(akm_field[7:0]);
		body.push_back(akm_field[15:8]);
		for (j = 0; j < akms; j++) begin
			suite = {24'h000FAC, (j == akms - 1) ? akm_kind : SUITE_PSK};
			for (i = 0; i < 4; i++) body.push_back(suite[31 - 8 * i -: 8]);
		end
		cap_lo = {pmf, 7'($urandom_range(0, 127))};
		if (cap_len > 0) body.push_back(cap_lo);
		if (cap_len > 1) body.push_back(8'($urandom_range(0, 255)));
		repeat (extra) body.push_back(8'($urandom_range(0, 255)));
		len = body.size();
		frm.push_back(EID_RSN);
		frm.push_back(len[7:0]);
		foreach (body[i]) frm.push_back(body[i]);
	endtask

	// sends the frame built so far, cut to keep bytes when keep is in range
	task automatic send_frame(input int keep);
		int i;
		int n;
		int gap;
		if (frm.size() == 0) add_fill(1);
		n = (keep > 0 && keep < frm.size()) ? keep : frm.size();
		calm = ($urandom_range(0, 4) == 0);
		for (i = 0; i < n; i++) begin
			gap = idle_len();
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			in_valid = 1'b1;
			frame_byte = frm[i];
			last_byte = (i == n - 1);
			do @(posedge clk); while (in_stall);
			@(negedge clk);
			sent_bytes++;
			if (i >= cur_offset) walked++;
		end
		in_valid = 1'b0;
		sent_frames++;
		frm.delete();
	endtask

	task automatic set_offset(input logic [7:0] v);
		wait (pending == 0);
		repeat (4) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		cur_offset = v;
		settings_used++;
	endtask

	task automatic random_frame();
		int r;
		int pairs;
		int akms;
		if ($urandom_range(0, 9) == 0) add_fill($urandom_range(0, cur_offset + 6));
		else add_fill(cur_offset);
		repeat ($urandom_range(0, 4)) begin
			r = $urandom_range(0, 99);
			pairs = $urandom_range(0, 3);
			akms = $urandom_range(0, 4);
			if (r < 35) begin
				add_rsn(pairs, pairs, akms, akms, pick_akm(), 1'($urandom_range(0, 1)), 2,
					($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
			end else if (r < 47) begin
				case ($urandom_range(0, 3))
					0: add_rsn($urandom_range(0, 65535), pairs, akms, akms, pick_akm(),
						1'($urandom_range(0, 1)), 2, 0);
					1: add_rsn(pairs, pairs, akms + $urandom_range(1, 5), akms, pick_akm(),
						1'($urandom_range(0, 1)), $urandom_range(0, 2), 0);
					2: add_rsn(pairs, pairs, akms, akms, pick_akm(),
						1'($urandom_range(0, 1)), $urandom_range(0, 1), 0);
					default: add_misc(EID_RSN, $urandom_range(0, 30));
				endcase
			end else if (r < 65) begin
				add_wpa($urandom_range(6, 12), -1);
			end else if (r < 75) begin
				add_wpa($urandom_range(0, 12), $urandom_range(0, 4));
			end else if (r < 92) begin
				add_misc(8'($urandom_range(0, 255)), $urandom_range(0, 12));
			end else begin
				add_misc(EID_VENDOR, $urandom_range(0, 10));
			end
		end
		if ($urandom_range(0, 9) == 0) add_fill($urandom_range(1, 5));
		if (frm.size() == 0) add_fill(1);
		send_frame(($urandom_range(0, 6) == 0) ? $urandom_range(1, frm.size()) : 0);
	endtask

	initial begin
		int offsets[5];
		int p;
		logic [7:0] off;
		arst_n = 1'b0;
		in_valid = 1'b0;
		frame_byte = 8'd0;
		last_byte = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'd0;
		cur_offset = 8'd36;
		walked = 0;
		sent_bytes = 0;
		sent_frames = 0;
		settings_used = 0;
		calm = 1'b0;
		offsets = '{0, 255, 200, 1, 36};
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed frames at the reset offset
		add_fill(1);
		send_frame(0);
		add_fill(36);
		send_frame(0);
		add_fill(36);
		add_rsn(1, 1, 1, 1, SUITE_PSK, 0, 2, 0);
		send_frame(0);
		add_fill(36);
		add_rsn(1, 1, 1, 1, SUITE_SAE, 1, 2, 0);
		send_frame(0);
		add_fill(36);
		add_rsn(2, 2, 2, 2, SUITE_FT_SAE, 0, 2, 0);
		send_frame(0);
		add_fill(36);
		add_wpa(6, -1);
		send_frame(0);
		add_fill(36);
		add_wpa(5, -1);
		send_frame(0);
		add_fill(36);
		add_wpa(8, 3);
		add_wpa(8, 0);
		send_frame(0);
		add_fill(36);
		add_wpa(6, -1);
		add_rsn(1, 1, 1, 1, SUITE_PSK, 0, 2, 0);
		send_frame(0);
		// last RSN element wins
		add_fill(36);
		add_rsn(1, 1, 1, 1, SUITE_SAE, 1, 2, 0);
		add_rsn(1, 1, 1, 1, SUITE_PSK, 0, 2, 0);
		send_frame(0);
		add_fill(36);
		add_misc(EID_RSN, 0);
		send_frame(0);
		// second RSN cut short: first one stands
		add_fill(36);
		add_rsn(1, 1, 1, 1, SUITE_SAE, 1, 2, 0);
		add_rsn(1, 1, 1, 1, SUITE_PSK, 0, 2, 0);
		send_frame(frm.size() - 3);
		// frame ends on an id byte, then on a length byte
		add_fill(36);
		add_wpa(6, -1);
		frm.push_back(EID_RSN);
		send_frame(0);
		add_fill(36);
		add_wpa(6, -1);
		frm.push_back(EID_RSN);
		frm.push_back(8'd20);
		send_frame(0);
		add_fill(36);
		add_misc(EID_RSN, 0);
		send_frame(0);
		// pairwise count runs past the element
		add_fill(36);
		add_rsn(65535, 0, 1, 1, SUITE_SAE, 1, 2, 0);
		send_frame(0);
		add_fill(36);
		add_rsn(3, 0, 1, 1, SUITE_SAE, 1, 2, 0);
		send_frame(0);
		// AKM count larger than what fits
		add_fill(36);
		add_rsn(1, 1, 5, 1, SUITE_SAE, 1, 2, 0);
		send_frame(0);
		add_fill(36);
		add_rsn(1, 1, 2, 1, SUITE_SAE, 1, 1, 0);
		send_frame(0);
		add_fill(36);
		add_rsn(1, 1, 1, 1, SUITE_PSK, 1, 2, 5);
		send_frame(0);
		add_fill(36);
		add_misc(8'd0, 0);
		add_misc(8'd7, 5);
		add_misc(EID_VENDOR, 0);
		add_rsn(0, 0, 0, 0, SUITE_PSK, 1, 2, 0);
		send_frame(0);
		repeat (60) frm.push_back(8'hFF);
		send_frame(0);
		repeat (60) frm.push_back(8'h00);
		send_frame(0);

		// random frames over a series of element offsets
		p = 0;
		while (sent_bytes < WANT_ITEMS) begin
			off = (p < 5) ? 8'(offsets[p]) : 8'($urandom_range(0, 48));
			set_offset(off);
			repeat ((off > 100) ? 1 : $urandom_range(6, 12)) begin
				random_frame();
			end
			p++;
		end

		wait (pending == 0);
		repeat (6) @(negedge clk);
		$display("Sent %0d frames, %0d bytes, %0d at or past the element offset, %0d offset writes.",
			sent_frames, sent_bytes, walked, settings_used);
		$display("Checked %0d security results.", checked);
		if (mismatches == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
